// ===== design/b2l_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths and the per-channel f(t) result type for the BGR to Lab converter.
package b2l_pkg;

  // Tristimulus value, unsigned Q0.16
  localparam int TW = 16;
  // f(t), unsigned Q0.16 with room for 1.0
  localparam int FW = 17;

  // One channel's f(t) together with its threshold decision
  typedef struct packed {
    logic          above;
    logic [FW-1:0] f;
  } b2l_f_res_t;

endpackage

// ===== design/bgr_to_lab_converter_core.sv =====
`timescale 1ns / 1ps
// Top level: nine-stage pipelined converter from 8-bit BGR pixels to 8-bit CIE Lab (D65).
// One pixel is accepted per cycle while the output is not stalled; data passes nine register stages:
// sums, two for the XYZ divide, three for f(t), three for L, a, b and clamping; all advance together
// and hold while the output is stalled.
// Reset clears the stage valid bits only; the root tables are constant ROMs and need no fill.
module bgr_to_lab_converter_core
  import b2l_pkg::*;
#(
  parameter int RootTableDepth = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] blue_i,
  input  logic [7:0] green_i,
  input  logic [7:0] red_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] lightness_o,
  output logic [7:0] green_red_axis_o,
  output logic [7:0] blue_yellow_axis_o
);

  localparam int NumStages = 9;
  localparam int NumCh     = 3;

  // Channel sums and the divide by white point times 255
  localparam int NumW       = 29;
  localparam int RecipW     = 19;
  localparam int RecipShift = 46;
  localparam int ProdW      = NumW + RecipW;
  localparam int QW         = 17;
  localparam int RemW       = QW + NumW;

  localparam logic [NumW-1:0] CoefR [NumCh] = '{NumW'(412453), NumW'(212671), NumW'(19334)};
  localparam logic [NumW-1:0] CoefG [NumCh] = '{NumW'(357580), NumW'(715160), NumW'(119193)};
  localparam logic [NumW-1:0] CoefB [NumCh] = '{NumW'(180423), NumW'(72169), NumW'(950227)};

  localparam logic [63:0] DenX = 64'd950456 * 64'd255;
  localparam logic [63:0] DenY = 64'd1000000 * 64'd255;
  localparam logic [63:0] DenZ = 64'd1088754 * 64'd255;
  localparam logic [NumW-1:0] Den [NumCh] = '{NumW'(DenX), NumW'(DenY), NumW'(DenZ)};
  localparam logic [RecipW-1:0] Recip [NumCh] = '{
    RecipW'((64'd1 << RecipShift) / DenX),
    RecipW'((64'd1 << RecipShift) / DenY),
    RecipW'((64'd1 << RecipShift) / DenZ)
  };
  localparam logic [QW:0] SatQ = (QW+1)'(65535);

  // Linear lightness branch: floor(y * 9033 / 10) for y below the threshold
  localparam int LyTW      = 10;
  localparam int LyW       = 24;
  localparam int LyQW      = 20;
  localparam int LyProdW   = 48;
  localparam int RecipTenShift = 27;
  localparam logic [LyW-1:0] LyCoef = LyW'(9033);
  localparam logic [LyW-1:0] RecipTen = LyW'(((64'd1 << RecipTenShift) + 64'd9) / 64'd10);

  // Lab assembly
  localparam int LqW = 24;
  localparam int AbW = 27;
  localparam logic [LqW-1:0] LScale  = LqW'(116);
  localparam logic [LqW-1:0] LOffset = LqW'(16 * 65536);
  localparam logic [AbW-1:0] AScale  = AbW'(500);
  localparam logic [AbW-1:0] BScale  = AbW'(200);
  localparam logic [AbW-1:0] AbOffset = AbW'(128 * 65536);

  // lightness = floor(floor(lq * 51 / 2^18) / 5)
  localparam int LmW      = 29;
  localparam int LmShift  = 18;
  localparam int WW       = 11;
  localparam int FiveW    = 22;
  localparam int FiveShift = 13;
  localparam logic [LmW-1:0]   LMul  = LmW'(51);
  localparam logic [FiveW-1:0] RecipFive = FiveW'(((64'd1 << FiveShift) + 64'd4) / 64'd5);
  localparam logic [9:0] ByteMax = 10'd255;

  logic [NumStages-1:0] v_q;
  logic                 adv;

  logic [NumW-1:0]  num_d  [NumCh];
  logic [NumW-1:0]  num_q  [NumCh];
  logic [ProdW-1:0] prod2  [NumCh];
  logic [NumW-1:0]  num2_q [NumCh];
  logic [QW-1:0]    q0_q   [NumCh];
  logic [RemW-1:0]  qd     [NumCh];
  logic [RemW-1:0]  rem    [NumCh];
  logic [QW:0]      qsum   [NumCh];
  logic [TW-1:0]    t_d    [NumCh];
  logic [TW-1:0]    t_q    [NumCh];
  b2l_f_res_t       fres   [NumCh];

  logic [LyW-1:0]     ly1_q;
  logic [LyProdW-1:0] ly_scaled;
  logic [LyQW-1:0]    ly2_q;
  logic [LyQW-1:0]    ly3_q;

  logic [LqW-1:0] lq_d;
  logic [LqW-1:0] lq_q;
  logic [AbW-1:0] av_d;
  logic [AbW-1:0] av_q;
  logic [AbW-1:0] bv_d;
  logic [AbW-1:0] bv_q;

  logic [LmW-1:0] lm;
  logic [WW-1:0]  w_q;
  logic           lneg_q;
  logic [7:0]     a_d;
  logic [7:0]     b_d;
  logic [7:0]     a_q;
  logic [7:0]     b_q;

  logic [FiveW-1:0] lsc;
  logic [8:0]       l9;
  logic [7:0]       light_d;
  logic [7:0]       light_q;
  logic [7:0]       gr_q;
  logic [7:0]       by_q;

  // Advance every stage unless the result register is full and stalled
  assign adv        = !v_q[NumStages-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NumStages-2:0], in_valid_i && in_ready_o};
    end
  end

  // Stage one: weighted channel sums for X, Y, Z
  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      num_d[c] = CoefR[c] * NumW'(red_i) + CoefG[c] * NumW'(green_i)
               + CoefB[c] * NumW'(blue_i);
    end
  end

  // Stage two: quotient estimate by reciprocal, low by at most one
  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      prod2[c] = ProdW'(num_q[c]) * ProdW'(Recip[c]);
    end
  end

  // Stage three: correct the estimate and saturate to Q0.16
  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      qd[c]   = RemW'(q0_q[c]) * RemW'(Den[c]);
      rem[c]  = RemW'({num2_q[c], 16'h0000}) - qd[c];
      qsum[c] = (QW+1)'(q0_q[c]) + (QW+1)'(rem[c] >= RemW'(Den[c]));
      t_d[c]  = (qsum[c] > SatQ) ? SatQ[TW-1:0] : qsum[c][TW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < NumCh; c++) begin
        num_q[c]  <= num_d[c];
        num2_q[c] <= num_q[c];
        q0_q[c]   <= prod2[c][(RecipShift - TW) +: QW];
        t_q[c]    <= t_d[c];
      end
    end
  end

  // Stages four to six: f(t) for each channel
  for (genvar c = 0; c < NumCh; c++) begin : g_f
    b2l_lab_f #(
      .RootTableDepth(RootTableDepth)
    ) u_lab_f (
      .clk_i(clk_i),
      .adv_i(adv),
      .t_i  (t_q[c]),
      .res_o(fres[c])
    );
  end

  // Linear lightness in step with f(Y)
  assign ly_scaled = LyProdW'(ly1_q) * LyProdW'(RecipTen);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ly1_q <= LyW'(t_q[1][LyTW-1:0]) * LyCoef;
      ly2_q <= ly_scaled[RecipTenShift +: LyQW];
      ly3_q <= ly2_q;
    end
  end

  // Stage seven: L in Q16, a and b offset by 128 in Q16
  always_comb begin
    if (fres[1].above) begin
      lq_d = LqW'(fres[1].f) * LScale - LOffset;
    end else begin
      lq_d = LqW'(ly3_q);
    end
    av_d = AScale * (AbW'(fres[0].f) - AbW'(fres[1].f)) + AbOffset;
    bv_d = BScale * (AbW'(fres[1].f) - AbW'(fres[2].f)) + AbOffset;
  end

  // Stage eight: scale L, clamp a and b
  assign lm = LmW'(lq_q[LqW-2:0]) * LMul;

  always_comb begin
    if (av_q[AbW-1]) begin
      a_d = 8'd0;
    end else if (av_q[AbW-2:16] > ByteMax) begin
      a_d = ByteMax[7:0];
    end else begin
      a_d = av_q[23:16];
    end
    if (bv_q[AbW-1]) begin
      b_d = 8'd0;
    end else if (bv_q[AbW-2:16] > ByteMax) begin
      b_d = ByteMax[7:0];
    end else begin
      b_d = bv_q[23:16];
    end
  end

  // Stage nine: divide by five and clamp lightness
  assign lsc = FiveW'(w_q) * RecipFive;
  assign l9  = lsc[FiveShift +: 9];

  always_comb begin
    if (lneg_q) begin
      light_d = 8'd0;
    end else if (10'(l9) > ByteMax) begin
      light_d = ByteMax[7:0];
    end else begin
      light_d = l9[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lq_q    <= lq_d;
      av_q    <= av_d;
      bv_q    <= bv_d;
      w_q     <= lm[LmShift +: WW];
      lneg_q  <= lq_q[LqW-1];
      a_q     <= a_d;
      b_q     <= b_d;
      light_q <= light_d;
      gr_q    <= a_q;
      by_q    <= b_q;
    end
  end

  assign out_valid_o        = v_q[NumStages-1];
  assign lightness_o        = light_q;
  assign green_red_axis_o   = gr_q;
  assign blue_yellow_axis_o = by_q;

endmodule

// ===== design/b2l_lab_f.sv =====
`timescale 1ns / 1ps
// Three-stage pipelined f(t): cube root by table and interpolation, or the linear branch.
module b2l_lab_f
  import b2l_pkg::*;
#(
  parameter int RootTableDepth = 1024
) (
  input  logic       clk_i,
  input  logic       adv_i,
  input  logic [TW-1:0] t_i,
  output b2l_f_res_t res_o
);

  localparam int IdxW = $clog2(RootTableDepth);
  localparam int PW   = TW + IdxW;
  localparam logic [PW-1:0] DepthP = PW'(RootTableDepth);

  // t counts as above 0.008856 when t * 1e6 > 8856 * 2^16
  localparam logic [TW-1:0] ThreshT = TW'((64'd8856 * 64'd65536) / 64'd1000000 + 64'd1);

  // Linear branch: floor(t * 7787 / 1000) + 16/116, only used for t below the threshold
  localparam int LinTW    = 10;
  localparam int LinCoefW = 13;
  localparam int LinW     = LinTW + LinCoefW;
  localparam logic [LinCoefW-1:0] LinCoef = LinCoefW'(7787);
  localparam int RecipKShift = 33;
  localparam int RecipKW     = 24;
  localparam logic [RecipKW-1:0] RecipK =
    RecipKW'(((64'd1 << RecipKShift) + 64'd999) / 64'd1000);
  localparam int LinProdW = LinW + RecipKW;
  localparam int LinQW    = 13;
  localparam logic [FW-1:0] LinBias = FW'((64'd16 << 16) / 64'd116);

  localparam int CbrtSteps = 18;
  localparam logic [63:0] CbrtHi = 64'd65537;

  typedef logic [2*TW-1:0] rom_word_t;
  typedef rom_word_t rom_t [RootTableDepth];

  // Integer cube root by bisection, evaluated at elaboration only
  function automatic logic [TW:0] icbrt(logic [63:0] n);
    logic [63:0] lo_v;
    logic [63:0] hi_v;
    logic [63:0] mid_v;
    lo_v = 64'd0;
    hi_v = CbrtHi;
    for (int s = 0; s < CbrtSteps; s++) begin
      if (lo_v + 64'd1 < hi_v) begin
        mid_v = (lo_v + hi_v) >> 1;
        if (mid_v * mid_v * mid_v <= n) begin
          lo_v = mid_v;
        end else begin
          hi_v = mid_v;
        end
      end
    end
    return (TW+1)'(lo_v);
  endfunction

  // Each word holds {T[k+1] - T[k], T[k]}
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [TW:0] base_v;
    logic [TW:0] next_v;
    for (int k = 0; k < RootTableDepth; k++) begin
      base_v = icbrt((64'(k) << 48) / 64'(RootTableDepth));
      next_v = icbrt((64'(k + 1) << 48) / 64'(RootTableDepth));
      rom[k] = {TW'(next_v - base_v), TW'(base_v)};
    end
    return rom;
  endfunction

  localparam rom_t RootRom = build_rom();

  logic [PW-1:0]   pos;
  logic [IdxW-1:0] idx;

  rom_word_t         rom_q;
  logic [TW-1:0]     fr_q;
  logic              above1_q;
  logic [LinW-1:0]   lin_prod_q;

  logic [2*TW-1:0]   interp_prod;
  logic [LinProdW-1:0] lin_scaled;
  logic [TW-1:0]     base2_q;
  logic [TW-1:0]     interp2_q;
  logic [LinQW-1:0]  lin2_q;
  logic              above2_q;

  b2l_f_res_t        res_d;
  b2l_f_res_t        res_q;

  // Split t * depth into table index and interpolation fraction
  assign pos = PW'(t_i) * DepthP;
  assign idx = pos[TW +: IdxW];

  // Stage one: table read, threshold, linear product
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rom_q      <= RootRom[idx];
      fr_q       <= pos[TW-1:0];
      above1_q   <= (t_i >= ThreshT);
      lin_prod_q <= LinW'(t_i[LinTW-1:0]) * LinW'(LinCoef);
    end
  end

  // Stage two: interpolate between entries, divide the linear term by 1000
  assign interp_prod = (2*TW)'(rom_q[2*TW-1:TW]) * (2*TW)'(fr_q);
  assign lin_scaled  = LinProdW'(lin_prod_q) * LinProdW'(RecipK);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      base2_q   <= rom_q[TW-1:0];
      interp2_q <= interp_prod[2*TW-1:TW];
      lin2_q    <= lin_scaled[RecipKShift +: LinQW];
      above2_q  <= above1_q;
    end
  end

  // Stage three: pick the branch
  always_comb begin
    res_d.above = above2_q;
    if (above2_q) begin
      res_d.f = FW'(base2_q) + FW'(interp2_q);
    end else begin
      res_d.f = FW'(lin2_q) + LinBias;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
